@@ rtl/fixed_point_q24_8_alu_macros.svh @@
// assertion macros shared by the alu rtl
`ifndef FIXED_POINT_Q24_8_ALU_MACROS_SVH
`define FIXED_POINT_Q24_8_ALU_MACROS_SVH

// same-cycle implication, checked outside reset
`define FPA_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define FPA_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/fpa_pkg.sv @@
// shared types and constants for the q24.8 fixed-point alu
`default_nettype none
package fpa_pkg;

  localparam int DEF_FRAC_BITS = 8;
  localparam int DEF_WORD_BITS = 32;
  localparam int DEF_DIV_STEPS = 4;

  typedef enum logic [3:0] {
    OP_ADD     = 4'd0,
    OP_SUB     = 4'd1,
    OP_MUL     = 4'd2,
    OP_DIV     = 4'd3,
    OP_INC     = 4'd4,
    OP_DEC     = 4'd5,
    OP_CMP     = 4'd6,
    OP_MIN     = 4'd7,
    OP_MAX     = 4'd8,
    OP_FROM_INT = 4'd9,
    OP_TO_INT  = 4'd10
  } op_t;

  // status bits, less in the lowest position
  typedef struct packed {
    logic div_zero;
    logic overflow;
    logic greater;
    logic equal;
    logic less;
  } flags_t;

endpackage
`default_nettype wire

@@ rtl/fixed_point_q24_8_alu.sv @@
// Signed fixed-point alu (Q24.8 by default) in a fully pipelined datapath.
// Input channel in_*: one request per transaction, opcode plus two raw words.
// Output channel out_*: one result per request, in request order, with the
// result word and the less, equal, greater, overflow and div_zero flags.
// Every operation takes the same path, so results leave in order; the
// divider retires DIV_STEPS quotient bits per stage and sets the depth.
// Throughput is one transaction per cycle while out_tready is high. Each stage has its own valid bit
// and takes new data when it is empty or its content moves on, so bubbles are
// squeezed out while the receiver holds out_tready low; in_tready drops only
// once every stage is full. Nothing is lost or repeated under a stall.
// Synchronous active-low reset empties the pipeline; in_tready is high while it
// is empty, so the block accepts a request as soon as reset is released.
// Unknown opcodes give a zero result with all flags clear.
`default_nettype none
`include "fixed_point_q24_8_alu_macros.svh"
module fixed_point_q24_8_alu #(
  parameter int FRAC_BITS = fpa_pkg::DEF_FRAC_BITS,
  parameter int WORD_BITS = fpa_pkg::DEF_WORD_BITS,
  parameter int DIV_STEPS = fpa_pkg::DEF_DIV_STEPS
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // req_type, operand_a, operand_b, zero pad
  input  logic [((2*WORD_BITS+4+7)/8)*8-1:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // result, less, equal, greater, overflow, div_zero, zero pad
  output logic [((WORD_BITS+5+7)/8)*8-1:0] out_tdata
);
  import fpa_pkg::*;

  localparam int W      = WORD_BITS;
  localparam int F      = FRAC_BITS;
  localparam int NB_RAW = W + F;
  localparam int NDS    = (NB_RAW + DIV_STEPS - 1) / DIV_STEPS;
  localparam int NB     = NDS * DIV_STEPS;
  localparam int L      = NDS + 3;
  localparam int OUT_W  = ((W + 5 + 7) / 8) * 8;

  localparam logic [W-1:0]   POS_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]   NEG_MIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [2*W-1:0] RND     = (2*W)'(1) << (F - 1);

  // pipeline control
  logic [L-1:0] v_r, v_nxt, go, v_in;

  always_comb begin
    go[L-1] = !v_r[L-1] || out_tready;
    for (int k = L - 2; k >= 0; k--) begin
      go[k] = !v_r[k] || go[k+1];
    end
  end

  assign v_in = {v_r[L-2:0], in_tvalid};

  always_comb begin
    for (int k = 0; k < L; k++) begin
      v_nxt[k] = go[k] ? v_in[k] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_tready = go[0];

  // stage 0: input register
  logic [3:0]   op_0_r;
  logic [W-1:0] a_0_r, b_0_r;

  always_ff @(posedge clk) begin
    if (go[0]) begin
      op_0_r <= in_tdata[3:0];
      a_0_r  <= in_tdata[W+3:4];
      b_0_r  <= in_tdata[2*W+3:W+4];
    end
  end

  // stage 0 -> 1: simple operations, multiplier, divider setup
  logic [W-1:0]    ma, mb, res_1_nxt, opb;
  logic [W:0]      sum_ext;
  logic [W+F-1:0]  fi_val, fi_lim;
  logic [W-1:0]    fi_mag;
  logic            sub_sel, sneg;
  flags_t          flg_1_nxt;

  assign ma   = a_0_r[W-1] ? (~a_0_r + 1'b1) : a_0_r;
  assign mb   = b_0_r[W-1] ? (~b_0_r + 1'b1) : b_0_r;
  assign sneg = a_0_r[W-1] ^ b_0_r[W-1];

  assign fi_val = {ma, {F{1'b0}}};
  assign fi_lim = a_0_r[W-1] ? (W+F)'(NEG_MIN) : (W+F)'(POS_MAX);
  assign fi_mag = (fi_val > fi_lim) ? fi_lim[W-1:0] : fi_val[W-1:0];

  always_comb begin
    sub_sel = (op_0_r == OP_SUB) || (op_0_r == OP_DEC);
    opb = ((op_0_r == OP_INC) || (op_0_r == OP_DEC)) ? W'(1) : b_0_r;
    sum_ext = sub_sel ? ({a_0_r[W-1], a_0_r} - {opb[W-1], opb})
                      : ({a_0_r[W-1], a_0_r} + {opb[W-1], opb});
    res_1_nxt = '0;
    flg_1_nxt = '0;
    case (op_t'(op_0_r))
      OP_ADD, OP_SUB, OP_INC, OP_DEC: begin
        if (sum_ext[W] != sum_ext[W-1]) begin
          flg_1_nxt.overflow = 1'b1;
          res_1_nxt = sum_ext[W] ? NEG_MIN : POS_MAX;
        end else begin
          res_1_nxt = sum_ext[W-1:0];
        end
      end
      OP_DIV: begin
        flg_1_nxt.div_zero = (b_0_r == '0);
      end
      OP_CMP: begin
        flg_1_nxt.less    = $signed(a_0_r) < $signed(b_0_r);
        flg_1_nxt.equal   = a_0_r == b_0_r;
        flg_1_nxt.greater = $signed(a_0_r) > $signed(b_0_r);
      end
      OP_MIN: res_1_nxt = ($signed(a_0_r) < $signed(b_0_r)) ? a_0_r : b_0_r;
      OP_MAX: res_1_nxt = ($signed(a_0_r) > $signed(b_0_r)) ? a_0_r : b_0_r;
      OP_FROM_INT: begin
        flg_1_nxt.overflow = fi_val > fi_lim;
        res_1_nxt = a_0_r[W-1] ? (~fi_mag + 1'b1) : fi_mag;
      end
      OP_TO_INT: res_1_nxt = W'($signed(a_0_r) >>> F);
      default: res_1_nxt = '0;
    endcase
  end

  // stage 1 registers
  logic [3:0]     op_1_r;
  logic [W-1:0]   res_1_r, den_1_r;
  flags_t         flg_1_r;
  logic           neg_1_r;
  logic [2*W-1:0] prod_1_r;
  logic [NB-1:0]  num_1_r;

  always_ff @(posedge clk) begin
    if (go[1]) begin
      op_1_r   <= op_0_r;
      res_1_r  <= res_1_nxt;
      flg_1_r  <= flg_1_nxt;
      neg_1_r  <= sneg;
      prod_1_r <= ma * mb;
      num_1_r  <= NB'({ma, {F{1'b0}}});
      den_1_r  <= mb;
    end
  end

  // stage 1 -> divider stage 0: round and saturate the product
  logic [2*W-1:0] mul_rnd, mul_sh, mul_lim;
  logic [W-1:0]   mul_mag;
  logic           mul_ovf;

  assign mul_rnd = prod_1_r + RND;
  assign mul_sh  = mul_rnd >> F;
  assign mul_lim = neg_1_r ? (2*W)'(NEG_MIN) : (2*W)'(POS_MAX);
  assign mul_ovf = mul_sh > mul_lim;
  assign mul_mag = mul_ovf ? mul_lim[W-1:0] : mul_sh[W-1:0];

  // side payload carried beside the divider
  logic [3:0]   op_s   [NDS];
  logic [W-1:0] res_s  [NDS];
  flags_t       flg_s  [NDS];
  logic         neg_s  [NDS];
  logic [3:0]   op_d_r [NDS];
  logic [W-1:0] res_d_r[NDS];
  flags_t       flg_d_r[NDS];
  logic         neg_d_r[NDS];

  always_comb begin
    op_s[0]  = op_1_r;
    res_s[0] = res_1_r;
    flg_s[0] = flg_1_r;
    neg_s[0] = neg_1_r;
    if (op_1_r == OP_MUL) begin
      res_s[0] = neg_1_r ? (~mul_mag + 1'b1) : mul_mag;
      flg_s[0].overflow = mul_ovf;
    end
    for (int k = 1; k < NDS; k++) begin
      op_s[k]  = op_d_r[k-1];
      res_s[k] = res_d_r[k-1];
      flg_s[k] = flg_d_r[k-1];
      neg_s[k] = neg_d_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NDS; k++) begin
      if (go[k+2]) begin
        op_d_r[k]  <= op_s[k];
        res_d_r[k] <= res_s[k];
        flg_d_r[k] <= flg_s[k];
        neg_d_r[k] <= neg_s[k];
      end
    end
  end

  // divider chain
  logic [W-1:0]  rem_w [NDS+1];
  logic [NB-1:0] num_w [NDS+1];
  logic [NB-1:0] quo_w [NDS+1];
  logic [W-1:0]  den_w [NDS+1];

  assign rem_w[0] = '0;
  assign num_w[0] = num_1_r;
  assign quo_w[0] = '0;
  assign den_w[0] = den_1_r;

  for (genvar k = 0; k < NDS; k++) begin : g_div
    fpa_div_stage #(
      .WORD_BITS(W),
      .NUM_BITS (NB),
      .DIV_STEPS(DIV_STEPS)
    ) u_stage (
      .clk  (clk),
      .en   (go[k+2]),
      .rem_i(rem_w[k]),
      .num_i(num_w[k]),
      .quo_i(quo_w[k]),
      .den_i(den_w[k]),
      .rem_o(rem_w[k+1]),
      .num_o(num_w[k+1]),
      .quo_o(quo_w[k+1]),
      .den_o(den_w[k+1])
    );
  end

  // last divider stage -> output register: round, saturate, select
  logic [W-1:0]  fin_rem, fin_den;
  logic [NB:0]   q_rnd, q_lim;
  logic [W-1:0]  q_mag, res_o_nxt;
  logic          q_inc, q_ovf, fin_neg;
  flags_t        flg_o_nxt;

  assign fin_rem = rem_w[NDS];
  assign fin_den = den_w[NDS];
  assign fin_neg = neg_d_r[NDS-1];
  // round half away from zero on the magnitude
  assign q_inc   = fin_rem >= (fin_den - fin_rem);
  assign q_rnd   = {1'b0, quo_w[NDS]} + (NB+1)'(q_inc);
  assign q_lim   = fin_neg ? (NB+1)'(NEG_MIN) : (NB+1)'(POS_MAX);
  assign q_ovf   = q_rnd > q_lim;
  assign q_mag   = q_ovf ? q_lim[W-1:0] : q_rnd[W-1:0];

  always_comb begin
    res_o_nxt = res_d_r[NDS-1];
    flg_o_nxt = flg_d_r[NDS-1];
    if ((op_d_r[NDS-1] == OP_DIV) && !flg_d_r[NDS-1].div_zero) begin
      res_o_nxt = fin_neg ? (~q_mag + 1'b1) : q_mag;
      flg_o_nxt.overflow = q_ovf;
    end
  end

  logic [W-1:0] res_o_r;
  flags_t       flg_o_r;

  always_ff @(posedge clk) begin
    if (go[L-1]) begin
      res_o_r <= res_o_nxt;
      flg_o_r <= flg_o_nxt;
    end
  end

  assign out_tvalid = v_r[L-1];
  assign out_tdata  = OUT_W'({flg_o_r, res_o_r});

  `FPA_ASSERT_NOW(a_dz_zero, clk, rst_n,
    out_tvalid && flg_o_r.div_zero, res_o_r == '0,
    "divide by zero with nonzero result")
  `FPA_ASSERT_NOW(a_cmp_onehot, clk, rst_n,
    out_tvalid, $onehot0({flg_o_r.less, flg_o_r.equal, flg_o_r.greater}),
    "more than one compare flag")
  `FPA_ASSERT_NOW(a_ovf_dz, clk, rst_n,
    out_tvalid, !(flg_o_r.overflow && flg_o_r.div_zero),
    "overflow together with div_zero")
  `FPA_ASSERT_NEXT(a_advance, clk, rst_n,
    v_r[0] && go[1], v_r[1],
    "stage 0 content lost on advance")

endmodule
`default_nettype wire

@@ rtl/fpa_div_stage.sv @@
// one pipeline stage of the restoring divider, several quotient bits per stage
`default_nettype none
module fpa_div_stage #(
  parameter int WORD_BITS = fpa_pkg::DEF_WORD_BITS,
  parameter int NUM_BITS  = fpa_pkg::DEF_WORD_BITS + fpa_pkg::DEF_FRAC_BITS,
  parameter int DIV_STEPS = fpa_pkg::DEF_DIV_STEPS
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [WORD_BITS-1:0] rem_i,
  input  logic [NUM_BITS-1:0]  num_i,
  input  logic [NUM_BITS-1:0]  quo_i,
  input  logic [WORD_BITS-1:0] den_i,
  output logic [WORD_BITS-1:0] rem_o,
  output logic [NUM_BITS-1:0]  num_o,
  output logic [NUM_BITS-1:0]  quo_o,
  output logic [WORD_BITS-1:0] den_o
);
  import fpa_pkg::*;

  logic [WORD_BITS-1:0] rem_r, rem_nxt;
  logic [NUM_BITS-1:0]  num_r, num_nxt;
  logic [NUM_BITS-1:0]  quo_r, quo_nxt;
  logic [WORD_BITS-1:0] den_r;

  always_comb begin
    logic [WORD_BITS:0] trial;
    rem_nxt = rem_i;
    num_nxt = num_i;
    quo_nxt = quo_i;
    for (int j = 0; j < DIV_STEPS; j++) begin
      // remainder stays below the divisor, so the difference fits the word
      trial = {rem_nxt, num_nxt[NUM_BITS-1]};
      num_nxt = {num_nxt[NUM_BITS-2:0], 1'b0};
      if (trial >= {1'b0, den_i}) begin
        trial = trial - {1'b0, den_i};
        quo_nxt = {quo_nxt[NUM_BITS-2:0], 1'b1};
      end else begin
        quo_nxt = {quo_nxt[NUM_BITS-2:0], 1'b0};
      end
      rem_nxt = trial[WORD_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r <= rem_nxt;
      num_r <= num_nxt;
      quo_r <= quo_nxt;
      den_r <= den_i;
    end
  end

  assign rem_o = rem_r;
  assign num_o = num_r;
  assign quo_o = quo_r;
  assign den_o = den_r;

endmodule
`default_nettype wire

@@ sim/tb_fixed_point_q24_8_alu.sv @@
// testbench for the q24.8 fixed-point alu: directed and random requests checked against a predictor
module tb_fixed_point_q24_8_alu;
  import fpa_pkg::*;

  localparam int FB = 8;
  localparam int INW = 72;
  localparam int OUTW = 40;
  localparam logic [31:0] QMAX = 32'h7fffffff;
  localparam logic [31:0] QMIN = 32'h80000000;

  typedef struct packed {
    logic        div_zero;
    logic        overflow;
    logic        greater;
    logic        equal;
    logic        less;
    logic [31:0] result;
  } alu_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [INW-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUTW-1:0] out_tdata;

  alu_res_t res_q[$];
  int errors = 0;
  bit quiet = 1'b0;
  bit hold_off = 1'b0;

  fixed_point_q24_8_alu u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // clamp a wide signed value to the 32-bit range
  function automatic logic [31:0] clamp(input logic signed [127:0] v, inout logic ovf);
    if (v > 128'sh7fffffff) begin
      ovf = 1'b1;
      return QMAX;
    end else if (v < -128'sh80000000) begin
      ovf = 1'b1;
      return QMIN;
    end
    return v[31:0];
  endfunction

  // apply the sign to a magnitude the caller rounded, ties away from zero
  function automatic logic signed [127:0] signmag(input logic neg, input logic [127:0] m);
    return neg ? -$signed(m) : $signed(m);
  endfunction

  function automatic alu_res_t alu_predict(input logic [3:0] op, input logic [31:0] a,
                                           input logic [31:0] b);
    alu_res_t r;
    logic signed [127:0] sa, sb;
    logic [127:0] ma, mb, q, rm;
    logic ovf;
    r = '0;
    ovf = 1'b0;
    sa = $signed(a);
    sb = $signed(b);
    ma = sa < 0 ? -sa : sa;
    mb = sb < 0 ? -sb : sb;
    case (op)
      OP_ADD: r.result = clamp(sa + sb, ovf);
      OP_SUB: r.result = clamp(sa - sb, ovf);
      OP_MUL: begin
        q = (ma * mb + (128'd1 << (FB - 1))) >> FB;
        r.result = clamp(signmag(a[31] ^ b[31], q), ovf);
      end
      OP_DIV: begin
        if (b == 0) r.div_zero = 1'b1;
        else begin
          q = (ma << FB) / mb;
          rm = (ma << FB) % mb;
          if (rm >= mb - rm) q = q + 1;
          r.result = clamp(signmag(a[31] ^ b[31], q), ovf);
        end
      end
      OP_INC: r.result = clamp(sa + 1, ovf);
      OP_DEC: r.result = clamp(sa - 1, ovf);
      OP_CMP: begin
        r.less = sa < sb;
        r.equal = a == b;
        r.greater = sa > sb;
      end
      OP_MIN: r.result = sa < sb ? a : b;
      OP_MAX: r.result = sa > sb ? a : b;
      OP_FROM_INT: r.result = clamp(sa <<< FB, ovf);
      OP_TO_INT: r.result = $signed(a) >>> FB;
      default: ;
    endcase
    r.overflow = ovf;
    return r;
  endfunction

  task automatic send_req(input logic [3:0] op, input logic [31:0] a, input logic [31:0] b);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {{(INW - 68){1'b0}}, b, a, op};
    res_q.push_back(alu_predict(op, a, b));
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    int n;
    in_tvalid <= 1'b0;
    n = 0;
    while (res_q.size() != 0 && n < 100000) begin
      @(posedge clk);
      n++;
    end
    repeat (20) @(posedge clk);
  endtask

  // receiver side: random stalls unless quiet, long hold when asked
  initial begin
    int gap;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_tready <= 1'b0;
        repeat (60) @(posedge clk);
        hold_off = 1'b0;
        out_tready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 15);
        out_tready <= 1'b0;
        repeat (gap - 1) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // checker
  always @(posedge clk) begin
    alu_res_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[36:0];
      if (res_q.size() == 0) begin
        $display("%0t unexpected transaction: expected none, actual %h", $time, got);
        errors++;
      end else begin
        want = res_q.pop_front();
        if (got.result !== want.result) begin
          $display("%0t result: expected %h actual %h", $time, want.result, got.result);
          errors++;
        end
        if (got.less !== want.less || got.equal !== want.equal ||
            got.greater !== want.greater) begin
          $display("%0t compare flags: expected %b%b%b actual %b%b%b", $time, want.less,
                   want.equal, want.greater, got.less, got.equal, got.greater);
          errors++;
        end
        if (got.overflow !== want.overflow) begin
          $display("%0t overflow: expected %b actual %b", $time, want.overflow, got.overflow);
          errors++;
        end
        if (got.div_zero !== want.div_zero) begin
          $display("%0t div_zero: expected %b actual %b", $time, want.div_zero, got.div_zero);
          errors++;
        end
      end
    end
  end

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 3) == 0 ? QMAX : ($urandom_range(0, 1) ? QMIN : 32'd0);
      1: return $urandom_range(0, 1024) - 512;
      2: return $signed($urandom_range(0, 32'h1ffff)) - 32'sh10000;
      3: return $urandom() >> $urandom_range(0, 31);
      default: return $urandom();
    endcase
  endfunction

  task automatic test_directed();
    op_t op;
    for (int k = 0; k <= 10; k++) begin
      op = op_t'(k);
      send_req(op, QMAX, QMAX);
      send_req(op, QMIN, 32'hffffffff);
    end
    send_req(OP_DIV, 32'h100, 32'd0);
    send_req(OP_MUL, 32'h80, 32'h80);
    send_req(OP_MUL, 32'hffffff80, 32'h80);
    send_req(OP_CMP, 32'd5, 32'd5);
    send_req(4'd11, 32'd1, 32'd2);
    send_req(4'd15, QMAX, QMIN);
    drain();
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    for (int i = 0; i < 60; i++)
      send_req(4'($urandom_range(0, 10)), rand_operand(), rand_operand());
    drain();
  endtask

  task automatic test_random(input int count);
    logic [3:0] op;
    for (int i = 0; i < count; i++) begin
      op = $urandom_range(0, 19) == 0 ? 4'($urandom_range(11, 15)) : 4'($urandom_range(0, 10));
      send_req(op, rand_operand(), rand_operand());
    end
    drain();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(1400);
    quiet = 1'b1;
    test_random(200);
    if (errors == 0 && res_q.size() == 0) begin
      $display("tb_fixed_point_q24_8_alu passed");
    end else begin
      $display("tb_fixed_point_q24_8_alu failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_fixed_point_q24_8_alu failed");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/fpa_pkg.sv
rtl/fpa_div_stage.sv
rtl/fixed_point_q24_8_alu.sv
sim/tb_fixed_point_q24_8_alu.sv
